// File: rtl/etm_pkg.sv
// Shared types, constants and the arctangent table for the Euler transform matrix block.
package etm_pkg;

  localparam int ANGLE_W         = 16;
  localparam int SCALE_W         = 16;
  localparam int OUT_W           = 32;
  localparam int COL_W           = 2;
  localparam int CORDIC_STEPS    = 28;
  localparam int STEPS_PER_STAGE = 4;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int CORDIC_W        = 33;
  localparam int CORDIC_LAT      = CORDIC_STAGES + 2;
  localparam int ROT_LAT         = 3;
  localparam int FRONT_LAT       = CORDIC_LAT + ROT_LAT;
  localparam int DIV_W           = 28;
  localparam int DIV_PER_STAGE   = 4;
  localparam int DIV_STAGES      = DIV_W / DIV_PER_STAGE;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [OUT_W-1:0]    ELEM_ONE    = 32'sd65536;
  localparam logic signed [OUT_W-1:0]    ELEM_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_W-1:0]    ELEM_MIN    = 32'sh8000_0000;

  localparam logic [COL_W-1:0] COL_FIRST   = 2'd0;
  localparam logic [COL_W-1:0] COL_SECOND  = 2'd1;
  localparam logic [COL_W-1:0] COL_THIRD   = 2'd2;
  localparam logic [COL_W-1:0] COL_OFFSET  = 2'd3;

  typedef enum logic {
    OP_MODEL  = 1'b0,
    OP_NORMAL = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic signed [SCALE_W-1:0] scale_z;
    logic signed [OUT_W-1:0]   offset_x;
    logic signed [OUT_W-1:0]   offset_y;
    logic signed [OUT_W-1:0]   offset_z;
  } side_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             normal;
    logic             last;
  } beat_ctl_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h2000_0000;
      1:  v = 32'h12E4_051E;
      2:  v = 32'h09FB_385B;
      3:  v = 32'h0511_11D4;
      4:  v = 32'h028B_0D43;
      5:  v = 32'h0145_D7E1;
      6:  v = 32'h00A2_F61E;
      7:  v = 32'h0051_7C55;
      8:  v = 32'h0028_BE53;
      9:  v = 32'h0014_5F2F;
      10: v = 32'h000A_2F98;
      11: v = 32'h0005_17CC;
      12: v = 32'h0002_8BE6;
      13: v = 32'h0001_45F3;
      14: v = 32'h0000_A2FA;
      15: v = 32'h0000_517D;
      16: v = 32'h0000_28BE;
      17: v = 32'h0000_145F;
      18: v = 32'h0000_0A30;
      19: v = 32'h0000_0518;
      20: v = 32'h0000_028C;
      21: v = 32'h0000_0146;
      22: v = 32'h0000_00A3;
      23: v = 32'h0000_0051;
      24: v = 32'h0000_0029;
      25: v = 32'h0000_0014;
      26: v = 32'h0000_000A;
      27: v = 32'h0000_0005;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/euler_transform_matrix.sv
// Each item leaves as its rotation columns and, in model mode, a translation column.
// Item throughput is set by the single result channel, which carries one column per
// cycle while out_ready is high; new items enter the front while earlier ones drain.
// Front CORDIC/product pipeline is 12 stages, column divider pipeline 9 stages.
// Reset clears all valid bits and the column sequencer; data registers are not reset.
module euler_transform_matrix #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic signed [15:0] in_angle_x,
  input  logic signed [15:0] in_angle_y,
  input  logic signed [15:0] in_angle_z,
  input  logic signed [15:0] in_scale_x,
  input  logic signed [15:0] in_scale_y,
  input  logic signed [15:0] in_scale_z,
  input  logic signed [31:0] in_offset_x,
  input  logic signed [31:0] in_offset_y,
  input  logic signed [31:0] in_offset_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_column,
  output logic signed [31:0] out_elem0,
  output logic signed [31:0] out_elem1,
  output logic signed [31:0] out_elem2,
  output logic signed [31:0] out_elem3,
  output logic        out_last,
  output logic        out_zero_scale
);

  localparam int TW = FRAC_BITS + 3;
  localparam int FL = etm_pkg::FRONT_LAT;

  logic en_front;
  logic en_col;
  logic ser_take;
  logic ser_fin;

  logic                 fv_r [FL];
  etm_pkg::side_t       sd_r [FL];
  etm_pkg::side_t       side_in;

  logic [2:0][etm_pkg::ANGLE_W-1:0] angles;
  logic [2:0][TW-1:0]               cos_w;
  logic [2:0][TW-1:0]               sin_w;
  logic [8:0][TW-1:0]               rot_w;

  logic                 ser_v_r;
  logic [1:0]           ser_col_r;
  etm_pkg::side_t       ser_side_r;
  logic [8:0][TW-1:0]   ser_rot_r;

  etm_pkg::beat_ctl_t               beat_ctl;
  logic [2:0][TW-1:0]               beat_rows;
  logic signed [etm_pkg::SCALE_W-1:0] beat_scale;
  logic [2:0][etm_pkg::OUT_W-1:0]   beat_offsets;

  logic                             col_v;
  etm_pkg::beat_ctl_t               col_ctl;
  logic                             col_zero;
  logic [3:0][etm_pkg::OUT_W-1:0]   col_elems;

  assign en_col   = !col_v || out_ready;
  assign ser_fin  = (ser_side_r.op == etm_pkg::OP_NORMAL) ? (ser_col_r == etm_pkg::COL_THIRD)
                                                          : (ser_col_r == etm_pkg::COL_OFFSET);
  assign ser_take = !ser_v_r || (en_col && ser_fin);
  assign en_front = !fv_r[FL-1] || ser_take;
  assign in_ready = en_front;

  assign angles  = {in_angle_z, in_angle_y, in_angle_x};
  assign side_in = '{op: etm_pkg::op_t'(in_op), scale_x: in_scale_x, scale_y: in_scale_y,
                     scale_z: in_scale_z, offset_x: in_offset_x, offset_y: in_offset_y,
                     offset_z: in_offset_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FL; i++) begin
        fv_r[i] <= 1'b0;
      end
    end else if (en_front) begin
      fv_r[0] <= in_valid;
      for (int i = 1; i < FL; i++) begin
        fv_r[i] <= fv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_front) begin
      sd_r[0] <= side_in;
      for (int i = 1; i < FL; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  etm_cordic #(
    .ANGLE_BITS (ANGLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cordic (
    .clk     (clk),
    .en      (en_front),
    .angle_i (angles),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  etm_rotation #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rotation (
    .clk   (clk),
    .en    (en_front),
    .cos_i (cos_w),
    .sin_i (sin_w),
    .rot_o (rot_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r   <= 1'b0;
      ser_col_r <= etm_pkg::COL_FIRST;
    end else if (ser_take) begin
      ser_v_r   <= fv_r[FL-1];
      ser_col_r <= etm_pkg::COL_FIRST;
    end else if (en_col && ser_v_r) begin
      ser_col_r <= ser_col_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_side_r <= sd_r[FL-1];
      ser_rot_r  <= rot_w;
    end
  end

  always_comb begin
    beat_ctl.col    = ser_col_r;
    beat_ctl.normal = (ser_side_r.op == etm_pkg::OP_NORMAL);
    beat_ctl.last   = ser_fin;
    beat_offsets    = {ser_side_r.offset_z, ser_side_r.offset_y, ser_side_r.offset_x};
    case (ser_col_r)
      etm_pkg::COL_FIRST: begin
        beat_rows  = {ser_rot_r[2], ser_rot_r[1], ser_rot_r[0]};
        beat_scale = ser_side_r.scale_x;
      end
      etm_pkg::COL_SECOND: begin
        beat_rows  = {ser_rot_r[5], ser_rot_r[4], ser_rot_r[3]};
        beat_scale = ser_side_r.scale_y;
      end
      etm_pkg::COL_THIRD: begin
        beat_rows  = {ser_rot_r[8], ser_rot_r[7], ser_rot_r[6]};
        beat_scale = ser_side_r.scale_z;
      end
      default: begin
        beat_rows  = '0;
        beat_scale = '0;
      end
    endcase
  end

  etm_column #(
    .FRAC_BITS (FRAC_BITS)
  ) u_column (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en_col),
    .beat_v       (ser_v_r),
    .beat_ctl     (beat_ctl),
    .beat_rows    (beat_rows),
    .beat_scale   (beat_scale),
    .beat_offsets (beat_offsets),
    .out_v        (col_v),
    .out_ctl      (col_ctl),
    .out_zero     (col_zero),
    .out_elems    (col_elems)
  );

  assign out_valid      = col_v;
  assign out_column     = col_ctl.col;
  assign out_last       = col_ctl.last;
  assign out_zero_scale = col_zero;
  assign out_elem0      = $signed(col_elems[0]);
  assign out_elem1      = $signed(col_elems[1]);
  assign out_elem2      = $signed(col_elems[2]);
  assign out_elem3      = $signed(col_elems[3]);

  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_column == etm_pkg::COL_THIRD ||
                               out_column == etm_pkg::COL_OFFSET))
    else $error("last flag on a middle column");

  a_zero_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_scale |-> (out_column != etm_pkg::COL_OFFSET))
    else $error("zero scale flag on translation column");

  a_w_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_column == etm_pkg::COL_OFFSET) == (out_elem3 == etm_pkg::ELEM_ONE)))
    else $error("row 3 entry does not match column");

  a_ser_step: assert property (@(posedge clk) disable iff (!rst_n)
    ser_v_r && en_col && !ser_fin |=>
      ser_v_r && (ser_col_r == 2'($past(ser_col_r) + 2'd1)))
    else $error("column sequencer skipped a column");

endmodule

// File: rtl/etm_cordic.sv
// Three-lane pipelined CORDIC producing cosine and sine of each binary angle.
module etm_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [2:0][etm_pkg::ANGLE_W-1:0]      angle_i,
  output logic [2:0][FRAC_BITS+2:0]             cos_o,
  output logic [2:0][FRAC_BITS+2:0]             sin_o
);

  localparam int TW = FRAC_BITS + 3;
  localparam int CW = etm_pkg::CORDIC_W;
  localparam int NS = etm_pkg::CORDIC_STAGES;
  localparam int SP = etm_pkg::STEPS_PER_STAGE;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic [31:0] KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  localparam logic signed [CW-1:0] TRND = CW'(1) <<< (SH - 1);

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [CW-1:0] x_r [NS+1];
    logic signed [CW-1:0] y_r [NS+1];
    logic signed [CW-1:0] z_r [NS+1];
    logic [1:0]           q_r [NS+1];
    logic [31:0]          phase;
    logic [31:0]          qsum;
    logic [31:0]          resid;
    logic signed [CW-1:0] cx_full;
    logic signed [CW-1:0] cy_full;
    logic signed [TW-1:0] cx;
    logic signed [TW-1:0] cy;
    logic signed [TW-1:0] cos_nxt;
    logic signed [TW-1:0] sin_nxt;
    logic [TW-1:0]        cos_r;
    logic [TW-1:0]        sin_r;

    always_comb begin
      phase = {angle_i[l], 16'h0000} & KEEP;
      qsum  = phase + 32'h2000_0000;
      resid = phase - {qsum[31:30], 30'd0};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[0] <= etm_pkg::CORDIC_GAIN;
        y_r[0] <= '0;
        z_r[0] <= CW'($signed(resid));
        q_r[0] <= qsum[31:30];
      end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stg
      logic signed [CW-1:0] xs [SP+1];
      logic signed [CW-1:0] ys [SP+1];
      logic signed [CW-1:0] zs [SP+1];

      always_comb begin
        xs[0] = x_r[s];
        ys[0] = y_r[s];
        zs[0] = z_r[s];
        for (int k = 0; k < SP; k++) begin
          if (!zs[k][CW-1]) begin
            xs[k+1] = xs[k] - (ys[k] >>> (s * SP + k));
            ys[k+1] = ys[k] + (xs[k] >>> (s * SP + k));
            zs[k+1] = zs[k] - $signed({1'b0, etm_pkg::atan_turn(s * SP + k)});
          end else begin
            xs[k+1] = xs[k] + (ys[k] >>> (s * SP + k));
            ys[k+1] = ys[k] - (xs[k] >>> (s * SP + k));
            zs[k+1] = zs[k] + $signed({1'b0, etm_pkg::atan_turn(s * SP + k)});
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[s+1] <= xs[SP];
          y_r[s+1] <= ys[SP];
          z_r[s+1] <= zs[SP];
          q_r[s+1] <= q_r[s];
        end
      end
    end

    always_comb begin
      cx_full = (x_r[NS] + TRND) >>> SH;
      cy_full = (y_r[NS] + TRND) >>> SH;
      cx      = cx_full[TW-1:0];
      cy      = cy_full[TW-1:0];
      case (q_r[NS])
        2'd0: begin
          cos_nxt = cx;
          sin_nxt = cy;
        end
        2'd1: begin
          cos_nxt = -cy;
          sin_nxt = cx;
        end
        2'd2: begin
          cos_nxt = -cx;
          sin_nxt = -cy;
        end
        default: begin
          cos_nxt = cy;
          sin_nxt = -cx;
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cos_r <= cos_nxt;
        sin_r <= sin_nxt;
      end
    end

    assign cos_o[l] = cos_r;
    assign sin_o[l] = sin_r;
  end

endmodule

// File: rtl/etm_rotation.sv
// Three-stage product and sum pipeline forming the nine rotation entries.
module etm_rotation #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [2:0][FRAC_BITS+2:0] cos_i,
  input  logic [2:0][FRAC_BITS+2:0] sin_i,
  output logic [8:0][FRAC_BITS+2:0] rot_o
);

  localparam int TW = FRAC_BITS + 3;
  localparam logic signed [2*TW-1:0] FRND = (2*TW)'(1) <<< (FRAC_BITS - 1);

  function automatic logic signed [TW-1:0] fmul(input logic signed [TW-1:0] a,
                                                input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    logic signed [2*TW-1:0] ps;
    p  = a * b;
    ps = (p + FRND) >>> FRAC_BITS;
    return ps[TW-1:0];
  endfunction

  logic signed [TW-1:0] c1, s1, c2, s2, c3, s3;

  assign c2 = $signed(cos_i[0]);
  assign s2 = $signed(sin_i[0]);
  assign c1 = $signed(cos_i[1]);
  assign s1 = $signed(sin_i[1]);
  assign c3 = $signed(cos_i[2]);
  assign s3 = $signed(sin_i[2]);

  logic signed [TW-1:0] c1c3_r, s1s2_r, c2s3_r, c1s2_r, c3s1_r, c2c3_r;
  logic signed [TW-1:0] s1s3_r, c2s1_r, c1c2_r, c1s3_r, s2_r, s3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1c3_r <= fmul(c1, c3);
      s1s2_r <= fmul(s1, s2);
      c2s3_r <= fmul(c2, s3);
      c1s2_r <= fmul(c1, s2);
      c3s1_r <= fmul(c3, s1);
      c2c3_r <= fmul(c2, c3);
      s1s3_r <= fmul(s1, s3);
      c2s1_r <= fmul(c2, s1);
      c1c2_r <= fmul(c1, c2);
      c1s3_r <= fmul(c1, s3);
      s2_r   <= s2;
      s3_r   <= s3;
    end
  end

  logic signed [TW-1:0] t00_r, t02_r, t10_r, t12_r;
  logic signed [TW-1:0] c1c3_2r, c2s3_2r, c3s1_2r, c1s3_2r, c2c3_2r;
  logic signed [TW-1:0] s1s3_2r, c2s1_2r, c1c2_2r, s2_2r;

  always_ff @(posedge clk) begin
    if (en) begin
      t00_r   <= fmul(s1s2_r, s3_r);
      t02_r   <= fmul(c1s2_r, s3_r);
      t10_r   <= fmul(c3s1_r, s2_r);
      t12_r   <= fmul(c1c3_r, s2_r);
      c1c3_2r <= c1c3_r;
      c2s3_2r <= c2s3_r;
      c3s1_2r <= c3s1_r;
      c1s3_2r <= c1s3_r;
      c2c3_2r <= c2c3_r;
      s1s3_2r <= s1s3_r;
      c2s1_2r <= c2s1_r;
      c1c2_2r <= c1c2_r;
      s2_2r   <= s2_r;
    end
  end

  logic [8:0][TW-1:0] rot_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r[0] <= c1c3_2r + t00_r;
      rot_r[1] <= c2s3_2r;
      rot_r[2] <= t02_r - c3s1_2r;
      rot_r[3] <= t10_r - c1s3_2r;
      rot_r[4] <= c2c3_2r;
      rot_r[5] <= t12_r + s1s3_2r;
      rot_r[6] <= c2s1_2r;
      rot_r[7] <= -s2_2r;
      rot_r[8] <= c1c2_2r;
    end
  end

  assign rot_o = rot_r;

endmodule

// File: rtl/etm_column.sv
// Column datapath: scale product, pipelined restoring divider and output register.
module etm_column #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 beat_v,
  input  etm_pkg::beat_ctl_t                   beat_ctl,
  input  logic [2:0][FRAC_BITS+2:0]            beat_rows,
  input  logic signed [etm_pkg::SCALE_W-1:0]   beat_scale,
  input  logic [2:0][etm_pkg::OUT_W-1:0]       beat_offsets,
  output logic                                 out_v,
  output etm_pkg::beat_ctl_t                   out_ctl,
  output logic                                 out_zero,
  output logic [3:0][etm_pkg::OUT_W-1:0]       out_elems
);

  localparam int TW  = FRAC_BITS + 3;
  localparam int DW  = etm_pkg::DIV_W;
  localparam int ND  = etm_pkg::DIV_STAGES;
  localparam int DP  = etm_pkg::DIV_PER_STAGE;
  localparam int SW  = etm_pkg::SCALE_W;
  localparam int OW  = etm_pkg::OUT_W;
  localparam int MS  = FRAC_BITS - 8;
  localparam int EW  = (TW + SW > 33) ? TW + SW : 33;
  localparam logic signed [EW-1:0] MRND = (MS == 0) ? EW'(0) : (EW'(1) <<< (MS - 1));
  localparam logic signed [EW-1:0] SMAX = EW'(etm_pkg::ELEM_MAX);
  localparam logic signed [EW-1:0] SMIN = EW'(etm_pkg::ELEM_MIN);

  logic                 v_r    [ND+1];
  etm_pkg::beat_ctl_t   ctl_r  [ND+1];
  logic                 zero_r [ND+1];
  logic [SW-1:0]        ad_r   [ND+1];
  logic [DW-1:0]        work_r [ND+1][3];
  logic [SW-1:0]        rem_r  [ND+1][3];
  logic                 neg_r  [ND+1][3];
  logic                 vpos_r [ND+1][3];
  logic                 vneg_r [ND+1][3];
  logic [OW-1:0]        mval_r [ND+1][3];

  logic [SW-1:0]        ad;
  logic [DW-1:0]        dvd    [3];
  logic [OW-1:0]        mval   [3];

  always_comb begin
    logic signed [TW-1:0] v;
    logic [TW-1:0]        an;
    logic signed [EW-1:0] prod;
    logic signed [EW-1:0] mv;
    ad = beat_scale[SW-1] ? SW'(-beat_scale) : SW'(beat_scale);
    for (int r = 0; r < 3; r++) begin
      v    = $signed(beat_rows[r]);
      an   = v[TW-1] ? TW'(-v) : TW'(v);
      dvd[r] = (DW'(an) << (24 - FRAC_BITS)) + DW'(ad >> 1);
      prod = EW'(v) * EW'(beat_scale);
      mv   = (prod + MRND) >>> MS;
      if (beat_ctl.col == etm_pkg::COL_OFFSET) begin
        mval[r] = beat_offsets[r];
      end else if (mv > SMAX) begin
        mval[r] = etm_pkg::ELEM_MAX;
      end else if (mv < SMIN) begin
        mval[r] = etm_pkg::ELEM_MIN;
      end else begin
        mval[r] = mv[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= beat_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0]  <= beat_ctl;
      zero_r[0] <= beat_ctl.normal && (beat_scale == '0);
      ad_r[0]   <= ad;
      for (int r = 0; r < 3; r++) begin
        work_r[0][r] <= dvd[r];
        rem_r[0][r]  <= '0;
        neg_r[0][r]  <= beat_rows[r][TW-1] ^ beat_scale[SW-1];
        vneg_r[0][r] <= beat_rows[r][TW-1];
        vpos_r[0][r] <= !beat_rows[r][TW-1] && (beat_rows[r] != '0);
        mval_r[0][r] <= mval[r];
      end
    end
  end

  for (genvar d = 0; d < ND; d++) begin : g_div
    logic [DW-1:0] wk [3][DP+1];
    logic [SW-1:0] rm [3][DP+1];

    always_comb begin
      logic [SW:0] t;
      for (int r = 0; r < 3; r++) begin
        wk[r][0] = work_r[d][r];
        rm[r][0] = rem_r[d][r];
        for (int k = 0; k < DP; k++) begin
          t = {rm[r][k], wk[r][k][DW-1]};
          if (t >= {1'b0, ad_r[d]}) begin
            rm[r][k+1] = SW'(t - {1'b0, ad_r[d]});
            wk[r][k+1] = {wk[r][k][DW-2:0], 1'b1};
          end else begin
            rm[r][k+1] = t[SW-1:0];
            wk[r][k+1] = {wk[r][k][DW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[d+1] <= 1'b0;
      end else if (en) begin
        v_r[d+1] <= v_r[d];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[d+1]  <= ctl_r[d];
        zero_r[d+1] <= zero_r[d];
        ad_r[d+1]   <= ad_r[d];
        for (int r = 0; r < 3; r++) begin
          work_r[d+1][r] <= wk[r][DP];
          rem_r[d+1][r]  <= rm[r][DP];
          neg_r[d+1][r]  <= neg_r[d][r];
          vneg_r[d+1][r] <= vneg_r[d][r];
          vpos_r[d+1][r] <= vpos_r[d][r];
          mval_r[d+1][r] <= mval_r[d][r];
        end
      end
    end
  end

  logic                 out_valid_r;
  etm_pkg::beat_ctl_t   out_ctl_r;
  logic                 out_zero_r;
  logic [3:0][OW-1:0]   elem_nxt;
  logic [3:0][OW-1:0]   elem_r;

  always_comb begin
    logic [OW-1:0] qv;
    for (int r = 0; r < 3; r++) begin
      qv = OW'(work_r[ND][r]);
      if (!ctl_r[ND].normal) begin
        elem_nxt[r] = mval_r[ND][r];
      end else if (zero_r[ND]) begin
        elem_nxt[r] = vpos_r[ND][r] ? etm_pkg::ELEM_MAX :
                      (vneg_r[ND][r] ? etm_pkg::ELEM_MIN : '0);
      end else begin
        elem_nxt[r] = neg_r[ND][r] ? -qv : qv;
      end
    end
    elem_nxt[3] = (ctl_r[ND].col == etm_pkg::COL_OFFSET) ? etm_pkg::ELEM_ONE : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl_r  <= ctl_r[ND];
      out_zero_r <= zero_r[ND];
      elem_r     <= elem_nxt;
    end
  end

  assign out_v     = out_valid_r;
  assign out_ctl   = out_ctl_r;
  assign out_zero  = out_zero_r;
  assign out_elems = elem_r;

endmodule

// File: tb/tb_top.sv
// Testbench for the Euler transform matrix block: directed table, random items, column checks.
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic [1:0]         col;
    logic signed [31:0] e0, e1, e2, e3;
    logic               last, zflag;
  } column_t;

  typedef struct {
    etm_pkg::op_t       op;
    logic signed [15:0] ax, ay, az, sx, sy, sz;
    logic signed [31:0] ox, oy, oz;
    logic               has_fixed;
    logic signed [31:0] fixed_e0;
  } xform_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = 1'b0;
  logic signed [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic signed [15:0] in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  logic signed [31:0] in_offset_x = '0, in_offset_y = '0, in_offset_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_column;
  logic signed [31:0] out_elem0, out_elem1, out_elem2, out_elem3;
  logic out_last, out_zero_scale;

  column_t pending_cols[$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;

  always #4 clk = ~clk;

  euler_transform_matrix DUT (.*);

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shift(a * b, 16);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic trig(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] phase, rem;
    logic [1:0]  quad;
    longint z, x, y, dx, dy, cx, cy;
    phase = {ang, 16'h0000};
    quad = 2'((phase + 32'h2000_0000) >> 30);
    rem = phase - {quad, 30'd0};
    z = longint'(signed'(rem));
    x = 652032874;
    y = 0;
    for (int i = 0; i < etm_pkg::CORDIC_STEPS; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(etm_pkg::atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(etm_pkg::atan_turn(i));
      end
    end
    cx = rnd_shift(x, 14);
    cy = rnd_shift(y, 14);
    case (quad)
      2'd0: begin c = cx; s = cy; end
      2'd1: begin c = -cy; s = cx; end
      2'd2: begin c = -cx; s = -cy; end
      default: begin c = cy; s = -cx; end
    endcase
  endtask

  function automatic longint div_near(longint num, longint den);
    longint an, ad, q;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = (an + ad / 2) / ad;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  task automatic predict_columns(input xform_t t);
    longint c1, s1, c2, s2, c3, s3;
    longint rot[3][3];
    longint scl[3];
    longint v, ent[3];
    column_t cl;
    trig(t.ax, c2, s2);
    trig(t.ay, c1, s1);
    trig(t.az, c3, s3);
    scl[0] = t.sx; scl[1] = t.sy; scl[2] = t.sz;
    rot[0][0] = qmul(c1, c3) + qmul(qmul(s1, s2), s3);
    rot[0][1] = qmul(c2, s3);
    rot[0][2] = qmul(qmul(c1, s2), s3) - qmul(c3, s1);
    rot[1][0] = qmul(qmul(c3, s1), s2) - qmul(c1, s3);
    rot[1][1] = qmul(c2, c3);
    rot[1][2] = qmul(qmul(c1, c3), s2) + qmul(s1, s3);
    rot[2][0] = qmul(c2, s1);
    rot[2][1] = -s2;
    rot[2][2] = qmul(c1, c2);
    for (int col = 0; col < 3; col++) begin
      cl.zflag = 1'b0;
      for (int row = 0; row < 3; row++) begin
        v = rot[col][row];
        if (t.op == etm_pkg::OP_MODEL) begin
          ent[row] = rnd_shift(v * scl[col], 8);
        end else if (scl[col] == 0) begin
          cl.zflag = 1'b1;
          ent[row] = v > 0 ? 64'sd2147483647 : (v < 0 ? -64'sd2147483648 : 0);
        end else begin
          ent[row] = div_near(v * 256, scl[col]);
        end
      end
      cl.col = 2'(col);
      cl.e0 = 32'(clamp32(ent[0]));
      cl.e1 = 32'(clamp32(ent[1]));
      cl.e2 = 32'(clamp32(ent[2]));
      cl.e3 = '0;
      cl.last = (t.op == etm_pkg::OP_NORMAL) && col == 2;
      if (col == 0 && t.has_fixed && cl.e0 != t.fixed_e0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row disagrees: elem0 %0d vs %0d", t.fixed_e0, cl.e0);
      end
      pending_cols.push_back(cl);
    end
    if (t.op == etm_pkg::OP_MODEL) begin
      cl.col = etm_pkg::COL_OFFSET;
      cl.e0 = t.ox; cl.e1 = t.oy; cl.e2 = t.oz;
      cl.e3 = etm_pkg::ELEM_ONE;
      cl.last = 1'b1;
      cl.zflag = 1'b0;
      pending_cols.push_back(cl);
    end
  endtask

  always @(posedge clk) begin
    column_t w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_cols.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected column %0d", out_column);
        end else begin
          w = pending_cols.pop_front();
          if (w.col !== out_column || w.e0 !== out_elem0 || w.e1 !== out_elem1 ||
              w.e2 !== out_elem2 || w.e3 !== out_elem3 || w.last !== out_last ||
              w.zflag !== out_zero_scale) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp col %0d %0d %0d %0d %0d l%0b z%0b",
                       w.col, w.e0, w.e1, w.e2, w.e3, w.last, w.zflag);
              $display("         got col %0d %0d %0d %0d %0d l%0b z%0b",
                       out_column, out_elem0, out_elem1, out_elem2, out_elem3,
                       out_last, out_zero_scale);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(input xform_t t);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= t.op;
    in_angle_x <= t.ax; in_angle_y <= t.ay; in_angle_z <= t.az;
    in_scale_x <= t.sx; in_scale_y <= t.sy; in_scale_z <= t.sz;
    in_offset_x <= t.ox; in_offset_y <= t.oy; in_offset_z <= t.oz;
    predict_columns(t);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cols.size() != 0) @(posedge clk);
  endtask

  function automatic xform_t mk(etm_pkg::op_t op, int ax, int ay, int az,
                                int sx, int sy, int sz,
                                int ox, int oy, int oz, bit hf, int fe0);
    xform_t t;
    t.op = op; t.ax = 16'(ax); t.ay = 16'(ay); t.az = 16'(az);
    t.sx = 16'(sx); t.sy = 16'(sy); t.sz = 16'(sz);
    t.ox = ox; t.oy = oy; t.oz = oz;
    t.has_fixed = hf; t.fixed_e0 = fe0;
    return t;
  endfunction

  function automatic xform_t rand_xform();
    xform_t t;
    t.op = etm_pkg::op_t'($urandom_range(1));
    t.ax = 16'($urandom); t.ay = 16'($urandom); t.az = 16'($urandom);
    t.sx = ($urandom_range(9) == 0) ? 16'sd0 : 16'($urandom);
    t.sy = ($urandom_range(9) == 0) ? 16'sd0 : 16'($urandom);
    t.sz = ($urandom_range(9) == 0) ? 16'sd0 : 16'($urandom_range(1)) ? 16'($urandom)
           : 16'($urandom_range(512) - 256);
    t.ox = $urandom; t.oy = $urandom; t.oz = $urandom;
    t.has_fixed = 1'b0; t.fixed_e0 = 0;
    return t;
  endfunction

  xform_t table_rows[$];

  initial begin
    table_rows = '{
      mk(etm_pkg::OP_MODEL, 0, 0, 0, 256, 256, 256, 0, 0, 0, 1, 65536),
      mk(etm_pkg::OP_NORMAL, 0, 0, 0, 256, 256, 256, 0, 0, 0, 1, 65536),
      mk(etm_pkg::OP_MODEL, 0, 0, 0, 32767, -32768, 1, 32'h7FFF_FFFF, 32'h8000_0000, -1,
         0, 0),
      mk(etm_pkg::OP_NORMAL, 0, 0, 0, 1, -1, -32768, 0, 0, 0, 0, 0),
      mk(etm_pkg::OP_NORMAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF),
      mk(etm_pkg::OP_MODEL, 0, 0, 0, 0, 0, 0, 5, 6, 7, 1, 0),
      mk(etm_pkg::OP_MODEL, 16384, 0, 0, 256, 256, 256, 0, 0, 0, 0, 0),
      mk(etm_pkg::OP_MODEL, 0, 16384, 0, 256, 256, 256, 0, 0, 0, 0, 0),
      mk(etm_pkg::OP_MODEL, 0, 0, 16384, 256, 256, 256, 0, 0, 0, 0, 0),
      mk(etm_pkg::OP_MODEL, -32768, -32768, -32768, 256, 256, 256, 0, 0, 0, 0, 0),
      mk(etm_pkg::OP_NORMAL, 32767, 32767, 32767, -256, 128, 3, 0, 0, 0, 0, 0),
      mk(etm_pkg::OP_NORMAL, 8192, -8192, 24576, 0, 512, 0, 0, 0, 0, 0, 0),
      mk(etm_pkg::OP_MODEL, -1, 1, 8192, 32767, 32767, 32767, 1, -1, 65536, 0, 0),
      mk(etm_pkg::OP_NORMAL, 12345, -23456, 4321, 1, 1, 1, 0, 0, 0, 0, 0)
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 12;
    recv_idle = 70;
    foreach (table_rows[i]) send(table_rows[i]);
    drain();
    for (int n = 0; n < 156; n++) begin
      if (n == 60) begin
        send_idle = 70; recv_idle = 12;
      end
      if (n == 120) begin
        send_idle = 0; recv_idle = 0;
      end
      if (n == 100)
        drain();
      send(rand_xform());
    end
    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
